@@ design/rse_pkg.sv @@
// shared types and codes for the randomized set engine
`timescale 1ns / 1ps
package rse_pkg;

	localparam int VALUE_W = 32;
	localparam int DRAW_W  = 31;
	localparam int COUNT_W = 7;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int DBIT_W  = $clog2(DRAW_W);

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_RANDOM = 2'd2;

	localparam status_t STAT_DONE  = 2'd0;
	localparam status_t STAT_MISS  = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;
	localparam status_t STAT_EMPTY = 2'd3;

endpackage

@@ design/rse_in_if.sv @@
// request channel: command, value and random draw
`timescale 1ns / 1ps
interface rse_in_if import rse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	cmd_t                      cmd;
	logic signed [VALUE_W-1:0] value;
	logic [DRAW_W-1:0]         random_draw;

	modport source (output valid, output cmd, output value, output random_draw, input ready);
	modport sink (input valid, input cmd, input value, input random_draw, output ready);
endinterface

@@ design/rse_out_if.sv @@
// response channel: status, picked member and member count
`timescale 1ns / 1ps
interface rse_out_if import rse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	status_t                   status;
	logic signed [VALUE_W-1:0] picked_value;
	logic [COUNT_W-1:0]        member_count;

	modport source (output valid, output status, output picked_value, output member_count,
		input ready);
	modport sink (input valid, input status, input picked_value, input member_count,
		output ready);
endinterface

@@ design/randomized_set_engine.sv @@
// randomized set engine: dense member store with insert, remove and random pick
// one request in flight; ready only while the sequencer is idle
// insert: linear scan of the store, one entry a cycle, one read port
// remove: scan, read of the last member, move into the freed slot
// random: 31-step restoring modulo of the draw, then one store read
// reset clears the count, sequencer and output valid flag; store contents stay undefined
`timescale 1ns / 1ps
module randomized_set_engine import rse_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	rse_in_if.sink    req,
	rse_out_if.source rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SCAN = 8'b0000_0010,
		S_LAST = 8'b0000_0100,
		S_MOVE = 8'b0000_1000,
		S_DIV  = 8'b0001_0000,
		S_PICK = 8'b0010_0000,
		S_GRAB = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rd_data_q;

	cmd_t               cmd_q;
	logic [VALUE_W-1:0] value_q;
	logic [DRAW_W-1:0]  draw_q;
	logic [DBIT_W-1:0]  bit_q;
	logic [CW-1:0]      rem_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      addr_q;
	logic [AW-1:0]      idx_s1;
	logic               pend_s1;
	logic [AW-1:0]      slot_q;
	status_t            res_stat_q;
	logic [VALUE_W-1:0] res_pick_q;

	logic               out_vq;
	status_t            out_stat_q;
	logic [VALUE_W-1:0] out_pick_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic               more;
	logic               scan_issue;
	logic               scan_hit;
	logic               scan_miss;
	logic               is_full;
	logic               resp_load;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic [CW:0]        rem_sh;
	logic               rem_ge;

	assign more       = addr_q < cnt_q;
	assign scan_hit   = (state_q == S_SCAN) && pend_s1 && (rd_data_q == value_q);
	assign scan_issue = (state_q == S_SCAN) && more && !scan_hit;
	assign scan_miss  = (state_q == S_SCAN) && !pend_s1 && !more;
	assign is_full    = cnt_q == CW'(CAPACITY);
	assign resp_load  = (state_q == S_RESP) && (!out_vq || rsp.ready);

	// compare/subtract step of the restoring modulo
	assign rem_sh = {rem_q, draw_q[DRAW_W-1]};
	assign rem_ge = rem_sh >= {1'b0, cnt_q};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q[AW-1:0];
		case (state_q)
			S_SCAN: begin
				rd_en = scan_issue;
			end
			S_LAST: begin
				rd_en   = 1'b1;
				rd_addr = AW'(cnt_q - 1'b1);
			end
			S_PICK: begin
				rd_en   = 1'b1;
				rd_addr = rem_q[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = value_q;
		if (scan_miss && cmd_q == CMD_INSERT && !is_full) begin
			wr_en = 1'b1;
		end else if (state_q == S_MOVE) begin
			wr_en   = 1'b1;
			wr_addr = slot_q;
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			out_vq  <= 1'b0;
		end else begin
			if (resp_load) begin
				out_vq <= 1'b1;
			end else if (rsp.ready) begin
				out_vq <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q      <= req.cmd;
						value_q    <= req.value;
						draw_q     <= req.random_draw;
						addr_q     <= '0;
						pend_s1    <= 1'b0;
						rem_q      <= '0;
						bit_q      <= DBIT_W'(DRAW_W - 1);
						res_stat_q <= (req.cmd == CMD_RANDOM && cnt_q == '0) ?
							STAT_EMPTY : STAT_DONE;
						res_pick_q <= '0;
						case (req.cmd)
							CMD_INSERT, CMD_REMOVE: begin
								state_q <= S_SCAN;
							end
							CMD_RANDOM: begin
								if (cnt_q == '0) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					// read of one entry overlaps the compare of the previous one
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						idx_s1 <= addr_q[AW-1:0];
						addr_q <= addr_q + 1'b1;
					end
					if (scan_hit) begin
						slot_q <= idx_s1;
						if (cmd_q == CMD_REMOVE) begin
							state_q <= S_LAST;
						end else begin
							res_stat_q <= STAT_MISS;
							state_q    <= S_RESP;
						end
					end else if (scan_miss) begin
						if (cmd_q == CMD_REMOVE) begin
							res_stat_q <= STAT_MISS;
						end else if (is_full) begin
							res_stat_q <= STAT_FULL;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_RESP;
				end
				S_DIV: begin
					rem_q  <= rem_ge ? CW'(rem_sh - {1'b0, cnt_q}) : rem_sh[CW-1:0];
					draw_q <= draw_q << 1;
					bit_q  <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					state_q <= S_GRAB;
				end
				S_GRAB: begin
					res_pick_q <= rd_data_q;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (resp_load) begin
						out_stat_q <= res_stat_q;
						out_pick_q <= res_pick_q;
						out_cnt_q  <= COUNT_W'(cnt_q);
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign rsp.valid        = out_vq;
	assign rsp.status       = out_stat_q;
	assign rsp.picked_value = out_pick_q;
	assign rsp.member_count = out_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("member count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == CW'($past(cnt_q) + 1'b1) ||
			cnt_q == CW'($past(cnt_q) - 1'b1)))
		else $error("member count moved by more than one");

	a_pick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vq && out_pick_q != '0) |-> out_stat_q == STAT_DONE)
		else $error("nonzero pick on a failed request");

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q != S_IDLE)
		else $error("store written while idle");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vq && out_stat_q == STAT_EMPTY) |-> out_cnt_q == '0)
		else $error("empty status with members present");

endmodule
